### rtl/antialiased_grid_pixel_shader_assert.svh
// Assertion helpers for the grid shader. Each macro expects clk and rst_n
// in the scope where it is used.
`ifndef ANTIALIASED_GRID_PIXEL_SHADER_ASSERT_SVH
`define ANTIALIASED_GRID_PIXEL_SHADER_ASSERT_SVH

`ifndef SYNTH
`define AGPS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define AGPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AGPS_ASSERT_IMPLIES(label, ante, cons, msg)
`define AGPS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/agps_pkg.sv
package agps_pkg;

  localparam int STAGES = 11;
  typedef logic [STAGES-1:0] stage_vec_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_ADDR_W-1:0] CFG_AA_MODE       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FEATHER_STEPS = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ZOOM_SCALE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRIFT_X       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRIFT_Y       = 3'd4;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_SMOOTH = 2'd1;
  localparam logic [1:0] MODE_BINARY = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [4:0]  STEPS_MIN     = 5'd1;
  localparam logic [4:0]  STEPS_MAX     = 5'd20;
  localparam logic [4:0]  FEATHER_RESET = 5'd2;
  localparam logic [14:0] ZOOM_RESET    = 15'd16384;

  localparam int COORD_SHIFT = 29;
  localparam int GRID_Q      = 2560;
  localparam int HALF_GRID_Q = 1280;
  localparam int LINE_HALF_Q = 128;
  // |c| / 2560 == (|c| >> 9) / 5, and x / 5 == (x * 205) >> 10 for x < 128
  localparam int GRID_SHIFT  = 9;
  localparam int DIV5_MUL    = 205;
  localparam int DIV5_SHIFT  = 10;
  localparam int RECIP_SHIFT = 21;
  localparam int ARC_MUL     = 95;
  localparam int ARC_BASE    = 15;

  typedef struct packed {
    logic [13:0]        radius_q;
    logic signed [15:0] arm_cos;
    logic signed [15:0] arm_sin;
    logic [15:0]        angle_fraction;
    logic               innermost_ring;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_out_t;

  typedef struct packed {
    logic [1:0]         aa_mode;
    logic [4:0]         steps;     // already clamped to 1..20
    logic [14:0]        zoom;
    logic signed [12:0] drift_x;
    logic signed [12:0] drift_y;
  } cfg_t;

  // floor(2^21 / s) for the linear ramp, floor(2^21 / s^3) for smoothstep
  function automatic logic [21:0] recip(input logic [1:0] mode, input logic [4:0] steps);
    logic [21:0] r;
    if (mode == MODE_SMOOTH) begin
      case (steps)
        5'd1:    r = 22'd2097152;
        5'd2:    r = 22'd262144;
        5'd3:    r = 22'd77672;
        5'd4:    r = 22'd32768;
        5'd5:    r = 22'd16777;
        5'd6:    r = 22'd9709;
        5'd7:    r = 22'd6114;
        5'd8:    r = 22'd4096;
        5'd9:    r = 22'd2876;
        5'd10:   r = 22'd2097;
        5'd11:   r = 22'd1575;
        5'd12:   r = 22'd1213;
        5'd13:   r = 22'd954;
        5'd14:   r = 22'd764;
        5'd15:   r = 22'd621;
        5'd16:   r = 22'd512;
        5'd17:   r = 22'd426;
        5'd18:   r = 22'd359;
        5'd19:   r = 22'd305;
        default: r = 22'd262;
      endcase
    end else begin
      case (steps)
        5'd1:    r = 22'd2097152;
        5'd2:    r = 22'd1048576;
        5'd3:    r = 22'd699050;
        5'd4:    r = 22'd524288;
        5'd5:    r = 22'd419430;
        5'd6:    r = 22'd349525;
        5'd7:    r = 22'd299593;
        5'd8:    r = 22'd262144;
        5'd9:    r = 22'd233016;
        5'd10:   r = 22'd209715;
        5'd11:   r = 22'd190650;
        5'd12:   r = 22'd174762;
        5'd13:   r = 22'd161319;
        5'd14:   r = 22'd149796;
        5'd15:   r = 22'd139810;
        5'd16:   r = 22'd131072;
        5'd17:   r = 22'd123361;
        5'd18:   r = 22'd116508;
        5'd19:   r = 22'd110376;
        default: r = 22'd104857;
      endcase
    end
    return r;
  endfunction

  // divisor matching recip(): s or s^3
  function automatic logic [12:0] divisor(input logic [1:0] mode, input logic [4:0] steps);
    logic [12:0] d;
    if (mode == MODE_SMOOTH) begin
      case (steps)
        5'd1:    d = 13'd1;
        5'd2:    d = 13'd8;
        5'd3:    d = 13'd27;
        5'd4:    d = 13'd64;
        5'd5:    d = 13'd125;
        5'd6:    d = 13'd216;
        5'd7:    d = 13'd343;
        5'd8:    d = 13'd512;
        5'd9:    d = 13'd729;
        5'd10:   d = 13'd1000;
        5'd11:   d = 13'd1331;
        5'd12:   d = 13'd1728;
        5'd13:   d = 13'd2197;
        5'd14:   d = 13'd2744;
        5'd15:   d = 13'd3375;
        5'd16:   d = 13'd4096;
        5'd17:   d = 13'd4913;
        5'd18:   d = 13'd5832;
        5'd19:   d = 13'd6859;
        default: d = 13'd8000;
      endcase
    end else begin
      d = {8'd0, steps};
    end
    return d;
  endfunction

  function automatic pixel_out_t mode_color(input logic [1:0] mode);
    pixel_out_t c;
    unique case (mode)
      MODE_LINEAR: c = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
      MODE_SMOOTH: c = '{red: 8'h00, green: 8'h00, blue: 8'hFF};
      MODE_BINARY: c = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
      default:     c = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
    endcase
    return c;
  endfunction

endpackage

### rtl/agps_stream_if.sv
interface agps_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/agps_axis.sv
// One Cartesian axis: radius * trig * zoom, round to Q8.8, add drift, fold
// into the distance to the nearest grid line. Occupies stages 1 to 5.
module agps_axis (
  input  logic                  clk,
  input  agps_pkg::stage_vec_t  stage_en,
  input  logic [13:0]           radius,
  input  logic signed [15:0]    trig,
  input  logic [14:0]           zoom,
  input  logic signed [12:0]    drift,
  output logic [10:0]           grid_d
);

  localparam int COORD_SHIFT_M1 = agps_pkg::COORD_SHIFT - 1;

  logic signed [30:0] rtrig_nxt;
  logic signed [30:0] rtrig_r;
  logic signed [46:0] scaled_nxt;
  logic signed [44:0] scaled_r;
  logic [43:0]        mag;
  logic [44:0]        mag_rnd;
  logic [15:0]        cmag_nxt;
  logic [15:0]        cmag_r;
  logic               cneg_r;
  logic signed [16:0] cmag_s;
  logic signed [16:0] coord;
  logic [16:0]        coord_abs;
  logic [15:0]        abs_r;
  logic [6:0]         abs_hi;
  logic [14:0]        quot_full;
  logic [4:0]         quot;
  logic [15:0]        rem;
  logic [11:0]        rem_lo;
  logic [10:0]        grid_d_nxt;
  logic [10:0]        grid_d_r;

  always_comb begin
    rtrig_nxt  = $signed({1'b0, radius}) * trig;
    scaled_nxt = rtrig_r * $signed({1'b0, zoom});

    // round half away from zero on the magnitude
    mag      = scaled_r[44] ? 44'(-scaled_r) : 44'(scaled_r);
    mag_rnd  = {1'b0, mag} + (45'd1 << (COORD_SHIFT_M1));
    cmag_nxt = 16'(mag_rnd >> agps_pkg::COORD_SHIFT);

    cmag_s    = $signed({1'b0, cmag_r});
    coord     = (cneg_r ? -cmag_s : cmag_s) + $signed({{4{drift[12]}}, drift});
    coord_abs = coord[16] ? 17'(-coord) : 17'(coord);

    abs_hi     = abs_r[15:agps_pkg::GRID_SHIFT];
    quot_full  = {8'd0, abs_hi} * 15'(agps_pkg::DIV5_MUL);
    quot       = quot_full[14:agps_pkg::DIV5_SHIFT];
    rem        = abs_r - ({11'd0, quot} * 16'(agps_pkg::GRID_Q));
    rem_lo     = rem[11:0];
    grid_d_nxt = (rem_lo > 12'(agps_pkg::HALF_GRID_Q)) ?
                 11'(12'(agps_pkg::GRID_Q) - rem_lo) : rem_lo[10:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      rtrig_r <= rtrig_nxt;
    end
    if (stage_en[1]) begin
      scaled_r <= scaled_nxt[44:0];
    end
    if (stage_en[2]) begin
      cmag_r <= cmag_nxt;
      cneg_r <= scaled_r[44];
    end
    if (stage_en[3]) begin
      abs_r <= coord_abs[15:0];
    end
    if (stage_en[4]) begin
      grid_d_r <= grid_d_nxt;
    end
  end

  assign grid_d = grid_d_r;

endmodule

### rtl/agps_ramp.sv
// Distance to opacity. Stages 6 to 11: ramp numerator, num^2 and the cubic
// weight, then floor(X / c) by reciprocal multiply and one correction step.
module agps_ramp (
  input  logic                 clk,
  input  agps_pkg::stage_vec_t stage_en,
  input  agps_pkg::cfg_t       cfg,
  input  logic [10:0]          dist_x,
  input  logic [10:0]          dist_y,
  output logic [7:0]           opacity
);

  typedef struct packed {
    logic lo;    // at or below the ramp: black
    logic hi;    // at or above the ramp: full
    logic bin;   // inside the half-pixel line
  } ramp_flags_t;

  logic [10:0]        gmin;
  logic [11:0]        base;
  logic signed [12:0] num;
  logic [11:0]        den;
  logic [13:0]        den3;
  ramp_flags_t        flags_nxt;
  ramp_flags_t        f6_r, f7_r, f8_r, f9_r, f10_r;
  logic [10:0]        num_r;

  logic [21:0]        sq_nxt;
  logic [21:0]        sq_r;
  logic [13:0]        wgt_full;
  logic [12:0]        wgt_r;
  logic [18:0]        lin_full;
  logic [11:0]        lin7_r;
  logic [11:0]        lin8_r;

  logic [34:0]        cube_nxt;
  logic [34:0]        cube_r;
  logic [42:0]        s255;
  logic [20:0]        x_nxt;
  logic [20:0]        x9_r;
  logic [20:0]        x10_r;

  logic [42:0]        est;
  logic [7:0]         q0_r;
  logic [12:0]        div_c;
  logic [20:0]        back;
  logic [20:0]        rem;
  logic [7:0]         quot;
  logic [7:0]         op_nxt;
  logic [7:0]         op_r;

  always_comb begin
    gmin = (dist_x < dist_y) ? dist_x : dist_y;
    base = {1'b0, cfg.steps, 6'd0} + 12'(agps_pkg::LINE_HALF_Q);
    num  = $signed({1'b0, base}) - $signed({2'b00, gmin});
    den  = {cfg.steps, 7'd0};
    den3 = ({2'b00, den} << 1) + {2'b00, den};

    flags_nxt.lo  = num[12] || (num == 13'sd0);
    flags_nxt.hi  = !num[12] && (num[11:0] >= den);
    flags_nxt.bin = gmin < 11'(agps_pkg::LINE_HALF_Q);

    sq_nxt   = {11'd0, num_r} * {11'd0, num_r};
    wgt_full = den3 - {2'b00, num_r, 1'b0};
    lin_full = {num_r, 8'd0} - {8'd0, num_r};

    cube_nxt = 35'(sq_r) * 35'(wgt_r);

    s255  = {cube_r, 8'd0} - {8'd0, cube_r};
    x_nxt = (cfg.aa_mode == agps_pkg::MODE_SMOOTH) ?
            s255[41:agps_pkg::RECIP_SHIFT] : {9'd0, lin8_r};

    est = 43'(x9_r) * 43'(agps_pkg::recip(cfg.aa_mode, cfg.steps));

    div_c = agps_pkg::divisor(cfg.aa_mode, cfg.steps);
    back  = 21'(q0_r) * 21'(div_c);
    rem   = x10_r - back;
    // estimate is low by at most one
    quot  = (rem >= 21'(div_c)) ? q0_r + 8'd1 : q0_r;

    case (cfg.aa_mode) inside
      agps_pkg::MODE_LINEAR, agps_pkg::MODE_SMOOTH: begin
        if (f10_r.lo) begin
          op_nxt = 8'd0;
        end else if (f10_r.hi) begin
          op_nxt = 8'hFF;
        end else begin
          op_nxt = quot;
        end
      end
      agps_pkg::MODE_BINARY: op_nxt = f10_r.bin ? 8'hFF : 8'd0;
      default:               op_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      num_r <= num[10:0];
      f6_r  <= flags_nxt;
    end
    if (stage_en[6]) begin
      sq_r   <= sq_nxt;
      wgt_r  <= wgt_full[12:0];
      lin7_r <= lin_full[18:7];
      f7_r   <= f6_r;
    end
    if (stage_en[7]) begin
      cube_r <= cube_nxt;
      lin8_r <= lin7_r;
      f8_r   <= f7_r;
    end
    if (stage_en[8]) begin
      x9_r <= x_nxt;
      f9_r <= f8_r;
    end
    if (stage_en[9]) begin
      q0_r  <= est[28:agps_pkg::RECIP_SHIFT];
      x10_r <= x9_r;
      f10_r <= f9_r;
    end
    if (stage_en[10]) begin
      op_r <= op_nxt;
    end
  end

  assign opacity = op_r;

endmodule

### rtl/antialiased_grid_pixel_shader.sv
// Channel  Dir  Payload                                                     Transfer when
// in_ch    in   radius_q arm_cos arm_sin angle_fraction innermost_ring      valid && ready
// out_ch   out  red green blue                                              valid && ready
// cfg      in   cfg_addr cfg_wdata                                          cfg_we
//
// One pixel per cycle unless out_ch stalls: two multiplies per axis, rounding,
// grid fold, then the ramp and a reciprocal-table divide, each in its own stage.
// A stage loads when it is empty or its successor loads, so bubbles close up
// under an output stall and in_ch.ready stays high while any stage is free.
// Synchronous reset empties all stages and loads the register defaults.
`include "antialiased_grid_pixel_shader_assert.svh"

module antialiased_grid_pixel_shader (
  input  logic                                clk,
  input  logic                                rst_n,
  agps_stream_if.sink                         in_ch,
  agps_stream_if.source                       out_ch,
  input  logic                                cfg_we,
  input  logic [agps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [agps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int STAGES = agps_pkg::STAGES;

  logic [1:0]           mode_r;
  logic [4:0]           feather_r;
  logic [14:0]          zoom_r;
  logic signed [12:0]   drift_x_r;
  logic signed [12:0]   drift_y_r;
  logic [4:0]           steps;
  agps_pkg::cfg_t       cfg;

  agps_pkg::stage_vec_t stage_en;
  agps_pkg::stage_vec_t valid_r;
  agps_pkg::stage_vec_t valid_nxt;
  agps_pkg::stage_vec_t ind_r;
  agps_pkg::stage_vec_t ind_nxt;

  logic [22:0]          arc_lhs;
  logic [22:0]          arc_rhs;
  logic                 in_arc;
  logic [10:0]          dist_x;
  logic [10:0]          dist_y;
  logic [7:0]           opacity;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= agps_pkg::MODE_LINEAR;
      feather_r <= agps_pkg::FEATHER_RESET;
      zoom_r    <= agps_pkg::ZOOM_RESET;
      drift_x_r <= '0;
      drift_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        agps_pkg::CFG_AA_MODE:       mode_r    <= cfg_wdata[1:0];
        agps_pkg::CFG_FEATHER_STEPS: feather_r <= cfg_wdata[4:0];
        agps_pkg::CFG_ZOOM_SCALE:    zoom_r    <= cfg_wdata[14:0];
        agps_pkg::CFG_DRIFT_X:       drift_x_r <= $signed(cfg_wdata[12:0]);
        agps_pkg::CFG_DRIFT_Y:       drift_y_r <= $signed(cfg_wdata[12:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (feather_r < agps_pkg::STEPS_MIN) begin
      steps = agps_pkg::STEPS_MIN;
    end else if (feather_r > agps_pkg::STEPS_MAX) begin
      steps = agps_pkg::STEPS_MAX;
    end else begin
      steps = feather_r;
    end
    cfg = '{aa_mode: mode_r, steps: steps, zoom: zoom_r,
            drift_x: drift_x_r, drift_y: drift_y_r};
  end

  // stage enables, from the output side back
  always_comb begin
    stage_en[STAGES-1] = !valid_r[STAGES-1] || out_ch.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  // indicator arc on the innermost ring
  always_comb begin
    arc_lhs = 23'(in_ch.payload.angle_fraction) * 23'(agps_pkg::ARC_MUL);
    arc_rhs = {7'(agps_pkg::ARC_BASE) + {steps, 2'b00}, 16'd0};
    in_arc  = (mode_r == agps_pkg::MODE_BINARY) || (arc_lhs <= arc_rhs);
  end

  assign valid_nxt = {valid_r[STAGES-2:0], in_ch.valid};
  assign ind_nxt   = {ind_r[STAGES-2:0], in_ch.payload.innermost_ring && in_arc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (stage_en[k]) begin
          valid_r[k] <= valid_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (stage_en[k]) begin
        ind_r[k] <= ind_nxt[k];
      end
    end
  end

  agps_axis u_axis_x (
    .clk      (clk),
    .stage_en (stage_en),
    .radius   (in_ch.payload.radius_q),
    .trig     (in_ch.payload.arm_cos),
    .zoom     (cfg.zoom),
    .drift    (cfg.drift_x),
    .grid_d   (dist_x)
  );

  agps_axis u_axis_y (
    .clk      (clk),
    .stage_en (stage_en),
    .radius   (in_ch.payload.radius_q),
    .trig     (in_ch.payload.arm_sin),
    .zoom     (cfg.zoom),
    .drift    (cfg.drift_y),
    .grid_d   (dist_y)
  );

  agps_ramp u_ramp (
    .clk      (clk),
    .stage_en (stage_en),
    .cfg      (cfg),
    .dist_x   (dist_x),
    .dist_y   (dist_y),
    .opacity  (opacity)
  );

  assign in_ch.ready  = stage_en[0];
  assign out_ch.valid = valid_r[STAGES-1];

  always_comb begin
    if (ind_r[STAGES-1]) begin
      out_ch.payload = agps_pkg::mode_color(mode_r);
    end else begin
      out_ch.payload = '{red: opacity, green: opacity, blue: opacity};
    end
  end

  `AGPS_ASSERT_IMPLIES(a_ready_when_free, !valid_r[STAGES-1] || out_ch.ready, in_ch.ready, "input stalled with a free pipeline")
  `AGPS_ASSERT_IMPLIES(a_gray_pixel, out_ch.valid && !ind_r[STAGES-1], out_ch.payload.red == out_ch.payload.green && out_ch.payload.green == out_ch.payload.blue, "grid pixel not gray")
  `AGPS_ASSERT_NEXT(a_fill_up, in_ch.valid && in_ch.ready && !(out_ch.valid && out_ch.ready), $countones(valid_r) == $past($countones(valid_r)) + 1, "pipeline lost an input transfer")
  `AGPS_ASSERT_NEXT(a_fill_down, out_ch.valid && out_ch.ready && !(in_ch.valid && in_ch.ready), $countones(valid_r) + 1 == $past($countones(valid_r)), "pipeline invented or kept a result")

endmodule

### tb/grid_shade_checker.sv
module grid_shade_checker
  import agps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  agps_stream_if                in_ch,
  agps_stream_if                out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  // shadow copy of the block's registers
  logic [1:0]         mode_reg;
  logic [4:0]         feather_reg;
  logic [14:0]        zoom_reg;
  logic signed [12:0] drift_x_reg;
  logic signed [12:0] drift_y_reg;

  pixel_out_t expected_pixels[$];
  pixel_out_t got_px;
  pixel_out_t want_px;

  // Q8.8 coordinate, rounded half away from zero
  function automatic longint scaled_coord(input longint radius, input longint trig);
    longint prod;
    longint mag;
    prod = radius * trig * longint'(zoom_reg);
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + (longint'(1) <<< 28)) >>> 29;
    return (prod < 0) ? -mag : mag;
  endfunction

  // distance to the nearest line of the 10 px grid
  function automatic longint line_distance(input longint c);
    longint d;
    d = ((c < 0) ? -c : c) % 2560;
    if (d > 1280) d = 2560 - d;
    return d;
  endfunction

  function automatic pixel_out_t shade_pixel(input pixel_in_t px);
    pixel_out_t res;
    longint     steps;
    longint     dx;
    longint     dy;
    longint     line_d;
    longint     den;
    longint     num;
    longint     level;
    bit         in_arc;
    steps = longint'(feather_reg);
    if (steps < 1) steps = 1;
    else if (steps > 20) steps = 20;
    case (mode_reg)
      MODE_LINEAR: res = '{8'h00, 8'hFF, 8'h00};
      MODE_SMOOTH: res = '{8'h00, 8'h00, 8'hFF};
      MODE_BINARY: res = '{8'hFF, 8'h00, 8'h00};
      default:     res = '{8'hFF, 8'hFF, 8'hFF};
    endcase
    in_arc = (mode_reg == MODE_BINARY) ||
             (longint'(px.angle_fraction) * 95 <= 65536 * (15 + 4 * steps));
    if (!(px.innermost_ring && in_arc)) begin
      dx = line_distance(scaled_coord(px.radius_q, $signed(px.arm_cos)) +
                         longint'(drift_x_reg));
      dy = line_distance(scaled_coord(px.radius_q, $signed(px.arm_sin)) +
                         longint'(drift_y_reg));
      line_d = (dx < dy) ? dx : dy;
      den = steps * 128;
      num = steps * 64 + 128 - line_d;
      level = 0;
      if (mode_reg == MODE_LINEAR || mode_reg == MODE_SMOOTH) begin
        if (num <= 0) level = 0;
        else if (num >= den) level = 255;
        else if (mode_reg == MODE_LINEAR) level = (255 * num) / den;
        else level = (255 * num * num * (3 * den - 2 * num)) / (den * den * den);
      end else if (mode_reg == MODE_BINARY) begin
        level = (line_d < 128) ? 255 : 0;
      end
      res = '{level[7:0], level[7:0], level[7:0]};
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_reg    = MODE_LINEAR;
      feather_reg = FEATHER_RESET;
      zoom_reg    = ZOOM_RESET;
      drift_x_reg = '0;
      drift_y_reg = '0;
      expected_pixels.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_px = out_ch.payload;
        if (expected_pixels.size() == 0) begin
          report_mismatch("result transfer with no pixel outstanding", int'(got_px), 0);
        end else begin
          want_px = expected_pixels.pop_front();
          if (got_px.red !== want_px.red)
            report_mismatch("red", int'(got_px.red), int'(want_px.red));
          if (got_px.green !== want_px.green)
            report_mismatch("green", int'(got_px.green), int'(want_px.green));
          if (got_px.blue !== want_px.blue)
            report_mismatch("blue", int'(got_px.blue), int'(want_px.blue));
        end
      end
      if (in_ch.valid && in_ch.ready) expected_pixels.push_back(shade_pixel(in_ch.payload));
      if (cfg_we) begin
        case (cfg_addr)
          CFG_AA_MODE:       mode_reg = cfg_wdata[1:0];
          CFG_FEATHER_STEPS: feather_reg = cfg_wdata[4:0];
          CFG_ZOOM_SCALE:    zoom_reg = cfg_wdata[14:0];
          CFG_DRIFT_X:       drift_x_reg = cfg_wdata[12:0];
          CFG_DRIFT_Y:       drift_y_reg = cfg_wdata[12:0];
          default: ;
        endcase
      end
    end
    pending = expected_pixels.size();
  end

endmodule

### tb/tb_antialiased_grid_pixel_shader.sv
module tb_antialiased_grid_pixel_shader;
  import agps_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    shade_fail;
  int                    shade_pending;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;

  // extremes of every field, arc boundary for the reset feather width,
  // a pixel right between two grid lines and one inside the ramp
  localparam pixel_in_t PROBES [6] = '{
    '{14'd0,     16'sh0000, 16'sh0000, 16'd0,     1'b0},
    '{14'd16383, 16'sh7FFF, 16'sh8000, 16'd65535, 1'b0},
    '{14'd16383, 16'sh8000, 16'sh7FFF, 16'd0,     1'b0},
    '{14'd1280,  16'sh7FFF, 16'sh7FFF, 16'd15867, 1'b1},
    '{14'd200,   16'sh7FFF, 16'sh7FFF, 16'd15866, 1'b1},
    '{14'd16383, 16'sh8000, 16'sh8000, 16'd65535, 1'b1}
  };

  agps_stream_if #(.payload_t(pixel_in_t))  in_ch ();
  agps_stream_if #(.payload_t(pixel_out_t)) out_ch ();

  antialiased_grid_pixel_shader dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  grid_shade_checker shade_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (shade_fail),
    .pending    (shade_pending)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

  // result side: long hold-offs are counted down here, otherwise random stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic [15:0] pick_trig();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_in_t rand_pixel();
    pixel_in_t p;
    case ($urandom_range(19))
      0:       p.radius_q = 14'd0;
      1:       p.radius_q = 14'd16383;
      default: p.radius_q = 14'($urandom_range(16383));
    endcase
    p.arm_cos        = pick_trig();
    p.arm_sin        = pick_trig();
    p.angle_fraction = 16'($urandom);
    p.innermost_ring = ($urandom_range(3) == 0);
    return p;
  endfunction

  // entered and left at a falling edge
  task automatic send_pixel(input pixel_in_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= p;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // drains the pipe first: registers only change while the block is idle
  task automatic apply_setting(input logic [1:0] mode, input logic [4:0] steps,
                               input logic [14:0] zoom, input logic signed [12:0] dx,
                               input logic signed [12:0] dy);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (shade_pending != 0);
    write_reg(CFG_AA_MODE, 15'(mode));
    write_reg(CFG_FEATHER_STEPS, 15'(steps));
    write_reg(CFG_ZOOM_SCALE, zoom);
    write_reg(CFG_DRIFT_X, {{2{dx[12]}}, dx});
    write_reg(CFG_DRIFT_Y, {{2{dy[12]}}, dy});
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed probes: reset registers first, then the corner settings
    for (int s = 0; s < 4; s++) begin
      case (s)
        1: apply_setting(MODE_SMOOTH, 5'd20, 15'd21299, 13'sd3840, -13'sd3840);
        2: apply_setting(MODE_BINARY, 5'd1, 15'd11469, -13'sd3840, 13'sd3840);
        3: apply_setting(MODE_NONE, 5'd31, 15'd32767, 13'sd0, 13'sd0);
        default: ;
      endcase
      foreach (PROBES[i]) send_pixel(PROBES[i]);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_setting(MODE_LINEAR, 5'd1, 15'd11469, -13'sd3840, 13'sd3840);
        1: apply_setting(MODE_SMOOTH, 5'd20, 15'd21299, 13'sd3840, -13'sd3840);
        2: apply_setting(MODE_BINARY, 5'($urandom_range(1, 20)), 15'd16384, 13'sd0, 13'sd0);
        3: apply_setting(MODE_NONE, 5'($urandom_range(1, 20)), 15'd16384, 13'sd256, 13'sd0);
        4: apply_setting(MODE_LINEAR, 5'd0, 15'd32767, 13'sd4095, -13'sd4096);
        5: apply_setting(MODE_SMOOTH, 5'd31, 15'd0, -13'sd4096, 13'sd4095);
        default: apply_setting(2'($urandom_range(3)), 5'($urandom_range(31)),
                               15'($urandom_range(32767)), 13'($urandom_range(8191)),
                               13'($urandom_range(8191)));
      endcase
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      // long output stall while pixels keep coming: pipe fills, input backs up
      if (ph % 4 == 0) rx_hold_left = 300;
      for (int n = 0; n < 140; n++) begin
        if (n == 70 && ph % 2 == 1) begin
          in_ch.valid <= 1'b0;
          do @(negedge clk); while (shade_pending != 0);
        end
        send_pixel(rand_pixel());
      end
    end

    in_ch.valid <= 1'b0;
    rx_stall_pct = 0;
    do @(negedge clk); while (shade_pending != 0);
    repeat (30) @(negedge clk);
    if (shade_fail == 0 && shade_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/agps_pkg.sv
rtl/agps_stream_if.sv
rtl/agps_axis.sv
rtl/agps_ramp.sv
rtl/antialiased_grid_pixel_shader.sv
tb/grid_shade_checker.sv
tb/tb_antialiased_grid_pixel_shader.sv
